/* hdl/wavhp_pkg.sv */
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types and constants of the WAV header parser: chunk tags, format
// limits, status codes and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] PCM_TAG  = 16'd1;
   localparam logic [15:0] PCM_BITS = 16'd16;
   localparam logic [31:0] FMT_LEN  = 32'd16;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_RIFF = 3'd1;
   localparam logic [2:0] ST_NO_FMT   = 3'd2;
   localparam logic [2:0] ST_BAD_FMT  = 3'd3;
   localparam logic [2:0] ST_NO_DATA  = 3'd4;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  data_byte;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] sample_rate;
      logic [15:0] channel_count;
      logic [31:0] data_length;
   } rsp_word_type;

endpackage

`default_nettype wire

/* hdl/wavhp_if.sv */
// ----------------------------------------------------------------------------
// wavhp_if
// Valid/ready channels of the WAV header parser: the byte stream in and the
// result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wavhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       first_byte;
   logic       final_byte;

   modport source (output valid, output byte_value, output first_byte,
                   output final_byte, input ready);
   modport sink (input valid, input byte_value, input first_byte,
                 input final_byte, output ready);
endinterface

interface wavhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_byte;
   logic [7:0]  data_byte;
   logic        done_res;
   logic [2:0]  status;
   logic [31:0] sample_rate;
   logic [15:0] channel_count;
   logic [31:0] data_length;

   modport source (output valid, output has_byte, output data_byte, output done_res,
                   output status, output sample_rate, output channel_count,
                   output data_length, input ready);
   modport sink (input valid, input has_byte, input data_byte, input done_res,
                 input status, input sample_rate, input channel_count,
                 input data_length, output ready);
endinterface

`default_nettype wire

/* hdl/wav_header_parser_core.sv */
// ----------------------------------------------------------------------------
// wav_header_parser_core
// Byte-serial RIFF/WAVE header parser with data chunk pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes the file one word per byte, in file order. first_byte
//   restarts parsing on that byte; final_byte marks the end of the stream.
//   rsp_bus gives zero or one word per byte: a data chunk byte (has_byte),
//   and on the word that ends the file, done_res with status and, when the
//   status is ok, sample rate, channel count and data length. Header bytes
//   and bytes after the end of a file give no word.
// Timing:
//   One byte per cycle sustained while rsp_bus does not stall. A byte accepted
//   at one edge shows its result word on rsp_bus from the next cycle: one output
//   register stage behind a combinational state update.
// Reset and stall:
//   Synchronous reset clears the parser to the RIFF header phase and empties
//   the output register; the first file may start without a first_byte mark.
//   While the receiver stalls, the output word holds and req_bus.ready stays
//   low only as long as that word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_parser_core (
   input  wire logic   clock,
   input  wire logic   reset,
   wavhp_req_if.sink   req_bus,
   wavhp_rsp_if.source rsp_bus
);

   logic                    step;
   logic                    res_valid;
   wavhp_pkg::rsp_word_type res_word;

   logic                    rsp_valid_ff, rsp_valid_in;
   wavhp_pkg::rsp_word_type rsp_word_ff,  rsp_word_in;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign step          = req_bus.valid && req_bus.ready;

   wavhp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (req_bus.byte_value),
      .first_byte (req_bus.first_byte),
      .final_byte (req_bus.final_byte),
      .res_valid  (res_valid),
      .res_word   (res_word)
   );

   // load a new word, drop a taken one, otherwise hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (step) begin
         rsp_valid_in = res_valid;
         rsp_word_in  = res_word;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.has_byte      = rsp_word_ff.has_byte;
   assign rsp_bus.data_byte     = rsp_word_ff.data_byte;
   assign rsp_bus.done_res      = rsp_word_ff.done_res;
   assign rsp_bus.status        = rsp_word_ff.status;
   assign rsp_bus.sample_rate   = rsp_word_ff.sample_rate;
   assign rsp_bus.channel_count = rsp_word_ff.channel_count;
   assign rsp_bus.data_length   = rsp_word_ff.data_length;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_valid_ff)
      else $error("input stalled with an empty output register");

   a_word_follows_step: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid) |=> rsp_valid_ff)
      else $error("result word of an accepted byte was lost");

   a_no_word_without_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !step) |=> !rsp_valid_ff)
      else $error("output word appeared without an accepted byte");

endmodule

`default_nettype wire

/* hdl/wavhp_parse.sv */
// ----------------------------------------------------------------------------
// wavhp_parse
// Parser state and its one-byte update: header check, chunk walk, fmt
// capture, skips and data pass-through. Produces at most one result word
// for each byte taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_parse (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            byte_value,
   input  wire logic                  first_byte,
   input  wire logic                  final_byte,
   output logic                       res_valid,
   output wavhp_pkg::rsp_word_type    res_word
);

   localparam logic [3:0] PH_HDR       = 4'd0;
   localparam logic [3:0] PH_FMT_CHDR  = 4'd1;
   localparam logic [3:0] PH_FMT_BODY  = 4'd2;
   localparam logic [3:0] PH_FMT_SKIP  = 4'd3;
   localparam logic [3:0] PH_EXT_SKIP  = 4'd4;
   localparam logic [3:0] PH_DATA_CHDR = 4'd5;
   localparam logic [3:0] PH_DATA_SKIP = 4'd6;
   localparam logic [3:0] PH_DATA_BODY = 4'd7;
   localparam logic [3:0] PH_DONE      = 4'd8;

   logic [3:0]  phase_ff,    phase_in,    phase_cur;
   logic [3:0]  count_ff,    count_in,    count_cur;
   logic [31:0] tag_ff,      tag_in,      tag_cur;
   logic [31:0] size_ff,     size_in,     size_cur;
   logic [31:0] skip_ff,     skip_in,     skip_cur;
   logic        pad_ff,      pad_in,      pad_cur;
   logic [15:0] fmt_ff,      fmt_in,      fmt_cur;
   logic [15:0] chan_ff,     chan_in,     chan_cur;
   logic [31:0] rate_ff,     rate_in,     rate_cur;
   logic [15:0] bits_ff,     bits_in,     bits_cur;
   logic        finished_ff, finished_in, finished_cur;

   logic        hb;
   logic        done;
   logic [2:0]  st;
   logic        ok;
   logic [31:0] ext_len;

   // A restart mark clears the state before this byte is parsed.
   always_comb begin
      phase_cur    = first_byte ? PH_HDR : phase_ff;
      count_cur    = first_byte ? 4'd0   : count_ff;
      tag_cur      = first_byte ? 32'd0  : tag_ff;
      size_cur     = first_byte ? 32'd0  : size_ff;
      skip_cur     = first_byte ? 32'd0  : skip_ff;
      pad_cur      = first_byte ? 1'b0   : pad_ff;
      fmt_cur      = first_byte ? 16'd0  : fmt_ff;
      chan_cur     = first_byte ? 16'd0  : chan_ff;
      rate_cur     = first_byte ? 32'd0  : rate_ff;
      bits_cur     = first_byte ? 16'd0  : bits_ff;
      finished_cur = first_byte ? 1'b0   : finished_ff;
   end

   assign ext_len = size_cur - wavhp_pkg::FMT_LEN;

   always_comb begin
      phase_in    = phase_cur;
      count_in    = count_cur;
      tag_in      = tag_cur;
      size_in     = size_cur;
      skip_in     = skip_cur;
      pad_in      = pad_cur;
      fmt_in      = fmt_cur;
      chan_in     = chan_cur;
      rate_in     = rate_cur;
      bits_in     = bits_cur;
      finished_in = finished_cur;
      hb          = 1'b0;
      done        = 1'b0;
      st          = wavhp_pkg::ST_OK;

      if (!finished_cur) begin
         case (phase_cur)
            PH_HDR: begin
               tag_in   = {tag_cur[23:0], byte_value};
               count_in = count_cur + 4'd1;
               if (count_cur == 4'd3 && tag_in != wavhp_pkg::TAG_RIFF) begin
                  done = 1'b1;
                  st   = wavhp_pkg::ST_BAD_RIFF;
               end else if (count_cur == 4'd11) begin
                  if (tag_in != wavhp_pkg::TAG_WAVE) begin
                     done = 1'b1;
                     st   = wavhp_pkg::ST_BAD_RIFF;
                  end else begin
                     phase_in = PH_FMT_CHDR;
                     count_in = 4'd0;
                  end
               end
            end
            PH_FMT_CHDR, PH_DATA_CHDR: begin
               if (count_cur < 4'd4) begin
                  tag_in = {tag_cur[23:0], byte_value};
               end else begin
                  size_in = {byte_value, size_cur[31:8]};
               end
               count_in = count_cur + 4'd1;
               if (count_cur == 4'd7) begin
                  count_in = 4'd0;
                  if (phase_cur == PH_FMT_CHDR) begin
                     if (tag_cur == wavhp_pkg::TAG_FMT && size_in >= wavhp_pkg::FMT_LEN) begin
                        phase_in = PH_FMT_BODY;
                     end else begin
                        skip_in  = size_in;
                        pad_in   = size_in[0];
                        phase_in = (size_in == 32'd0) ? PH_FMT_CHDR : PH_FMT_SKIP;
                     end
                  end else if (tag_cur == wavhp_pkg::TAG_DATA) begin
                     skip_in = size_in;
                     if (size_in == 32'd0) begin
                        done = 1'b1;
                     end else begin
                        phase_in = PH_DATA_BODY;
                     end
                  end else begin
                     skip_in  = size_in;
                     pad_in   = size_in[0];
                     phase_in = (size_in == 32'd0) ? PH_DATA_CHDR : PH_DATA_SKIP;
                  end
               end
            end
            PH_FMT_BODY: begin
               case (count_cur)
                  4'd0:    fmt_in[7:0]    = fmt_cur[7:0] | byte_value;
                  4'd1:    fmt_in[15:8]   = fmt_cur[15:8] | byte_value;
                  4'd2:    chan_in[7:0]   = chan_cur[7:0] | byte_value;
                  4'd3:    chan_in[15:8]  = chan_cur[15:8] | byte_value;
                  4'd4:    rate_in[7:0]   = rate_cur[7:0] | byte_value;
                  4'd5:    rate_in[15:8]  = rate_cur[15:8] | byte_value;
                  4'd6:    rate_in[23:16] = rate_cur[23:16] | byte_value;
                  4'd7:    rate_in[31:24] = rate_cur[31:24] | byte_value;
                  4'd14:   bits_in[7:0]   = bits_cur[7:0] | byte_value;
                  4'd15:   bits_in[15:8]  = bits_cur[15:8] | byte_value;
                  default: ;
               endcase
               count_in = count_cur + 4'd1;
               if (count_cur == 4'd15) begin
                  count_in = 4'd0;
                  if (fmt_in != wavhp_pkg::PCM_TAG || bits_in != wavhp_pkg::PCM_BITS) begin
                     done = 1'b1;
                     st   = wavhp_pkg::ST_BAD_FMT;
                  end else begin
                     // skip the fmt extension, plus pad after an odd size
                     skip_in  = ext_len;
                     pad_in   = size_cur[0];
                     phase_in = (ext_len == 32'd0 && !size_cur[0]) ? PH_DATA_CHDR
                                                                   : PH_EXT_SKIP;
                  end
               end
            end
            PH_FMT_SKIP, PH_EXT_SKIP, PH_DATA_SKIP: begin
               if (skip_cur != 32'd0) begin
                  skip_in = skip_cur - 32'd1;
               end else begin
                  pad_in = 1'b0;
               end
               if (skip_in == 32'd0 && !pad_in) begin
                  phase_in = (phase_cur == PH_FMT_SKIP) ? PH_FMT_CHDR : PH_DATA_CHDR;
               end
            end
            PH_DATA_BODY: begin
               hb = 1'b1;
               if (skip_cur != 32'd0) begin
                  skip_in = skip_cur - 32'd1;
               end
               if (skip_in == 32'd0) begin
                  done = 1'b1;
               end
            end
            default: ;
         endcase

         // early end of stream: status follows the phase reached
         if (!done && final_byte) begin
            done = 1'b1;
            if (phase_in == PH_HDR) begin
               st = wavhp_pkg::ST_BAD_RIFF;
            end else if (phase_in <= PH_FMT_SKIP) begin
               st = wavhp_pkg::ST_NO_FMT;
            end else begin
               st = wavhp_pkg::ST_NO_DATA;
            end
         end
         if (done) begin
            finished_in = 1'b1;
            phase_in    = PH_DONE;
         end
      end
   end

   assign ok        = done && st == wavhp_pkg::ST_OK;
   assign res_valid = !finished_cur && (hb || done);

   always_comb begin
      res_word.has_byte      = hb;
      res_word.data_byte     = hb ? byte_value : 8'd0;
      res_word.done_res      = done;
      res_word.status        = done ? st : wavhp_pkg::ST_OK;
      res_word.sample_rate   = ok ? rate_in : 32'd0;
      res_word.channel_count = ok ? chan_in : 16'd0;
      res_word.data_length   = ok ? size_in : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         count_ff    <= 4'd0;
         tag_ff      <= 32'd0;
         size_ff     <= 32'd0;
         skip_ff     <= 32'd0;
         pad_ff      <= 1'b0;
         fmt_ff      <= 16'd0;
         chan_ff     <= 16'd0;
         rate_ff     <= 32'd0;
         bits_ff     <= 16'd0;
         finished_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         tag_ff      <= tag_in;
         size_ff     <= size_in;
         skip_ff     <= skip_in;
         pad_ff      <= pad_in;
         fmt_ff      <= fmt_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         finished_ff <= finished_in;
      end
   end

   a_finished_phase: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> phase_ff == PH_DONE)
      else $error("finished parser is not in the done phase");

   a_done_latches: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && res_word.done_res) |=> finished_ff)
      else $error("ending word did not stop the parser");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_word.done_res) |-> (res_word.status == wavhp_pkg::ST_OK
                                             && res_word.has_byte))
      else $error("word without end carries status or no data byte");

   a_data_needs_body: assert property (@(posedge clock) disable iff (reset)
      (step && !first_byte && res_valid && res_word.has_byte) |-> phase_ff == PH_DATA_BODY)
      else $error("data byte passed outside the data chunk");

endmodule

`default_nettype wire

/* tb/tb_wav_header_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_wav_header_parser_core
// Drives whole WAV files, good and broken, into the parser one byte per word
// and checks every result word against a cycle-free model of the parser or a
// typed word. A short table of directed bytes comes first, then generated files
// of many shapes, with random gaps and stalls and one long result-side stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_wav_header_parser_core;

   typedef enum logic [3:0] {
      PH_HDR, PH_FMT_CHDR, PH_FMT_BODY, PH_FMT_SKIP, PH_EXT_SKIP,
      PH_DATA_CHDR, PH_DATA_SKIP, PH_DATA_BODY, PH_DONE
   } parse_phase_type;

   // how the expected word of a stimulus byte is obtained
   typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} check_mode_type;

   typedef enum int {
      SH_LONG, SH_GOOD, SH_BAD_MAGIC, SH_BAD_FMT, SH_DETOUR, SH_EMPTY,
      SH_TRUNC, SH_ABANDON, SH_OPEN, SH_NOISE
   } file_shape_type;

   typedef struct packed {
      logic [7:0]              b;
      logic                    first;
      logic                    last;
      check_mode_type          mode;
      wavhp_pkg::rsp_word_type word;
   } byte_item_type;

   typedef logic [7:0] octet_q_type [$];

   localparam wavhp_pkg::rsp_word_type NO_WORD = '0;
   localparam wavhp_pkg::rsp_word_type BAD_MAGIC_END =
      '{1'b0, 8'h00, 1'b1, wavhp_pkg::ST_BAD_RIFF, 32'h0, 16'h0, 32'h0};
   localparam int CALM_BYTES = 60;

   logic clock;
   logic reset;

   wavhp_req_if req_bus ();
   wavhp_rsp_if rsp_bus ();

   wav_header_parser_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // parser state of the model
   parse_phase_type ps_phase;
   logic [3:0]   ps_count;
   logic [31:0]  ps_tag;
   logic [31:0]  ps_size;
   logic [32:0]  ps_skip;
   logic         ps_pad;
   logic [15:0]  ps_fmt_tag;
   logic [15:0]  ps_chans;
   logic [31:0]  ps_rate;
   logic [15:0]  ps_bits;
   logic         ps_finished;

   byte_item_type           stim_q [$];
   wavhp_pkg::rsp_word_type owed_words [$];
   byte_item_type           cur_item;
   int           rx_idle_pct;
   int           fail_count;
   int           file_count;
   int           bytes_taken;
   int           words_seen;
   int           data_seen;
   int           status_tally [5];

   byte_item_type directed_rows [0:24] = '{
      // no restart mark after reset; "RIFX" fails on its fourth byte
      '{8'h52, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h49, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h46, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h58, 1'b0, 1'b0, CHK_TYPED, BAD_MAGIC_END},
      // ignored after the end, a final mark too
      '{8'hFF, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h00, 1'b0, 1'b1, CHK_QUIET, NO_WORD},
      // stream ends inside the RIFF header; then a bad first RIFF byte
      '{8'h52, 1'b1, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h49, 1'b0, 1'b1, CHK_TYPED, BAD_MAGIC_END},
      '{8'h00, 1'b1, 1'b1, CHK_TYPED, BAD_MAGIC_END},
      '{8'hFF, 1'b1, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h49, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h46, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h46, 1'b0, 1'b0, CHK_TYPED, BAD_MAGIC_END},
      // good RIFF, bad WAVE on the twelfth byte
      '{8'h52, 1'b1, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h49, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h46, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h46, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'hFF, 1'b0, 1'b0, CHK_MODEL, NO_WORD},
      '{8'h00, 1'b0, 1'b0, CHK_MODEL, NO_WORD},
      '{8'hFF, 1'b0, 1'b0, CHK_MODEL, NO_WORD},
      '{8'hA5, 1'b0, 1'b0, CHK_MODEL, NO_WORD},
      '{8'h57, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h41, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h56, 1'b0, 1'b0, CHK_QUIET, NO_WORD},
      '{8'h46, 1'b0, 1'b0, CHK_TYPED, BAD_MAGIC_END}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------------
   task automatic clear_parser();
      ps_phase    = PH_HDR;
      ps_count    = '0;
      ps_tag      = '0;
      ps_size     = '0;
      ps_skip     = '0;
      ps_pad      = 1'b0;
      ps_fmt_tag  = '0;
      ps_chans    = '0;
      ps_rate     = '0;
      ps_bits     = '0;
      ps_finished = 1'b0;
   endtask

   task automatic begin_skip(input parse_phase_type skip_ph, input parse_phase_type after,
                             input logic [32:0] count, input logic [31:0] size);
      ps_skip  = count;
      ps_pad   = size[0];
      ps_phase = (count == 0 && !size[0]) ? after : skip_ph;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic first, input logic last,
                             output logic produced, output wavhp_pkg::rsp_word_type w);
      logic       hb;
      logic       done;
      logic       ok;
      logic [2:0] st;
      logic [3:0] idx;
      hb = 1'b0;
      done = 1'b0;
      st = wavhp_pkg::ST_OK;
      produced = 1'b0;
      w = NO_WORD;
      if (first)
         clear_parser();
      if (ps_finished)
         return;
      idx = ps_count;
      case (ps_phase)
         PH_HDR: begin
            ps_tag = {ps_tag[23:0], b};
            if ((idx == 3 && ps_tag != wavhp_pkg::TAG_RIFF) ||
                (idx == 11 && ps_tag != wavhp_pkg::TAG_WAVE)) begin
               done = 1'b1;
               st = wavhp_pkg::ST_BAD_RIFF;
            end
            if (idx == 11 && !done) begin
               ps_phase = PH_FMT_CHDR;
               ps_count = '0;
            end else begin
               ps_count = idx + 4'd1;
            end
         end
         PH_FMT_CHDR, PH_DATA_CHDR: begin
            if (idx < 4)
               ps_tag = {ps_tag[23:0], b};
            else
               ps_size = {b, ps_size[31:8]};
            ps_count = idx + 4'd1;
            if (idx == 7) begin
               ps_count = '0;
               if (ps_phase == PH_FMT_CHDR) begin
                  if (ps_tag == wavhp_pkg::TAG_FMT && ps_size >= wavhp_pkg::FMT_LEN)
                     ps_phase = PH_FMT_BODY;
                  else
                     begin_skip(PH_FMT_SKIP, PH_FMT_CHDR, {1'b0, ps_size}, ps_size);
               end else if (ps_tag == wavhp_pkg::TAG_DATA) begin
                  ps_skip = {1'b0, ps_size};
                  if (ps_size == 0)
                     done = 1'b1;
                  else
                     ps_phase = PH_DATA_BODY;
               end else begin
                  begin_skip(PH_DATA_SKIP, PH_DATA_CHDR, {1'b0, ps_size}, ps_size);
               end
            end
         end
         PH_FMT_BODY: begin
            if (idx < 2)
               ps_fmt_tag = ps_fmt_tag | (16'(b) << (8 * idx));
            else if (idx < 4)
               ps_chans = ps_chans | (16'(b) << (8 * (idx - 2)));
            else if (idx < 8)
               ps_rate = ps_rate | (32'(b) << (8 * (idx - 4)));
            else if (idx >= 14)
               ps_bits = ps_bits | (16'(b) << (8 * (idx - 14)));
            ps_count = idx + 4'd1;
            if (idx == 15) begin
               ps_count = '0;
               if (ps_fmt_tag != wavhp_pkg::PCM_TAG || ps_bits != wavhp_pkg::PCM_BITS) begin
                  done = 1'b1;
                  st = wavhp_pkg::ST_BAD_FMT;
               end else begin
                  begin_skip(PH_EXT_SKIP, PH_DATA_CHDR,
                             {1'b0, ps_size} - 33'(wavhp_pkg::FMT_LEN), ps_size);
               end
            end
         end
         PH_FMT_SKIP, PH_EXT_SKIP, PH_DATA_SKIP: begin
            if (ps_skip != 0)
               ps_skip = ps_skip - 33'd1;
            else
               ps_pad = 1'b0;
            if (ps_skip == 0 && !ps_pad)
               ps_phase = (ps_phase == PH_FMT_SKIP) ? PH_FMT_CHDR : PH_DATA_CHDR;
         end
         PH_DATA_BODY: begin
            hb = 1'b1;
            if (ps_skip != 0)
               ps_skip = ps_skip - 33'd1;
            if (ps_skip == 0)
               done = 1'b1;
         end
         default: begin
         end
      endcase

      if (!done && last) begin
         done = 1'b1;
         if (ps_phase == PH_HDR)
            st = wavhp_pkg::ST_BAD_RIFF;
         else if (ps_phase <= PH_FMT_SKIP)
            st = wavhp_pkg::ST_NO_FMT;
         else
            st = wavhp_pkg::ST_NO_DATA;
      end
      if (done) begin
         ps_finished = 1'b1;
         ps_phase = PH_DONE;
      end
      if (hb || done) begin
         ok = done && st == wavhp_pkg::ST_OK;
         produced = 1'b1;
         w.has_byte      = hb;
         w.data_byte     = hb ? b : 8'h00;
         w.done_res      = done;
         w.status        = done ? st : wavhp_pkg::ST_OK;
         w.sample_rate   = ok ? ps_rate : 32'h0;
         w.channel_count = ok ? ps_chans : 16'h0;
         w.data_length   = ok ? ps_size : 32'h0;
      end
   endtask

   // ------------------------------------------------------------------------
   // file builder
   // ------------------------------------------------------------------------
   task automatic put_bytes(ref octet_q_type q, input logic [31:0] v, input int n,
                            input bit big);
      int k;
      for (k = 0; k < n; k++)
         q.push_back(big ? v[8 * (n - 1 - k) +: 8] : v[8 * k +: 8]);
   endtask

   task automatic put_chunk(ref octet_q_type q, input logic [31:0] tag,
                            input logic [31:0] size, input int body_len);
      put_bytes(q, tag, 4, 1'b1);
      put_bytes(q, size, 4, 1'b0);
      repeat (body_len) q.push_back(8'($urandom));
   endtask

   task automatic add_file(input file_shape_type shape);
      octet_q_type   f;
      byte_item_type item;
      int          open_at;
      int          ext;
      int          cut;
      int          k;
      logic [31:0] sz;
      logic [31:0] tag;
      logic [15:0] fmt_code;
      logic [15:0] bits;
      open_at = (shape == SH_OPEN) ? $urandom_range(0, 3) : -1;
      if (shape == SH_NOISE) begin
         repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
      end else begin
         put_bytes(f, wavhp_pkg::TAG_RIFF, 4, 1'b1);
         put_bytes(f, $urandom, 4, 1'b0);
         put_bytes(f, wavhp_pkg::TAG_WAVE, 4, 1'b1);
         if (shape == SH_BAD_MAGIC) begin
            k = $urandom_range(0, 11);
            f[k] = f[k] ^ (8'd1 << $urandom_range(0, 7));
         end
         // unknown, early data and short fmt chunks ahead of the real fmt
         for (k = 0; k < 3; k++)
            if (shape == SH_DETOUR || $urandom_range(0, 5) == 0) begin
               sz = (k == 2) ? $urandom_range(0, 15) : $urandom_range(0, 9);
               tag = (k == 0) ? 32'($urandom) :
                     (k == 1) ? wavhp_pkg::TAG_DATA : wavhp_pkg::TAG_FMT;
               put_chunk(f, tag, sz, sz + sz[0]);
            end
         if (open_at == 0) begin
            put_chunk(f, $urandom, $urandom | 32'h8000_0000, $urandom_range(0, 4));
         end else begin
            ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            sz = (open_at == 1) ? ($urandom | 32'h8000_0000) : 32'(16 + ext);
            fmt_code = wavhp_pkg::PCM_TAG;
            bits = wavhp_pkg::PCM_BITS;
            if (shape == SH_BAD_FMT)
               case ($urandom_range(0, 2))
                  0: fmt_code = 16'($urandom);
                  1: bits = 16'($urandom);
                  default: begin
                     fmt_code = 16'd3;
                     bits = 16'd32;
                  end
               endcase
            put_bytes(f, wavhp_pkg::TAG_FMT, 4, 1'b1);
            put_bytes(f, sz, 4, 1'b0);
            put_bytes(f, fmt_code, 2, 1'b0);
            put_bytes(f, $urandom, 2, 1'b0);
            put_bytes(f, $urandom, 4, 1'b0);
            put_bytes(f, $urandom, 4, 1'b0);
            put_bytes(f, $urandom, 2, 1'b0);
            put_bytes(f, bits, 2, 1'b0);
            if (open_at == 1) begin
               repeat ($urandom_range(0, 4)) f.push_back(8'($urandom));
            end else begin
               repeat (ext + ext % 2) f.push_back(8'($urandom));
               // unknown chunks and late fmt chunks before the data
               for (k = 0; k < 2; k++)
                  if (shape == SH_DETOUR || $urandom_range(0, 5) == 0) begin
                     sz = (k == 0) ? $urandom_range(0, 9) : $urandom_range(0, 20);
                     tag = (k == 0) ? 32'($urandom) : wavhp_pkg::TAG_FMT;
                     put_chunk(f, tag, sz, sz + sz[0]);
                  end
               if (open_at == 2) begin
                  put_chunk(f, $urandom, $urandom | 32'h8000_0000, $urandom_range(0, 4));
               end else if (open_at == 3) begin
                  put_chunk(f, wavhp_pkg::TAG_DATA, $urandom | 32'h8000_0000,
                            $urandom_range(0, 4));
               end else begin
                  if (shape == SH_EMPTY)
                     sz = 0;
                  else if (shape == SH_LONG)
                     sz = $urandom_range(20, 40);
                  else if ($urandom_range(0, 4) == 0)
                     sz = $urandom_range(9, 24);
                  else
                     sz = $urandom_range(1, 8);
                  put_chunk(f, wavhp_pkg::TAG_DATA, sz, sz);
                  repeat ($urandom_range(0, 2)) f.push_back(8'($urandom));
               end
            end
         end
      end

      if (shape == SH_TRUNC || shape == SH_ABANDON)
         cut = $urandom_range(0, f.size() - 1);
      else
         cut = f.size() - 1;
      for (k = 0; k <= cut; k++) begin
         item.b     = f[k];
         item.first = (k == 0);
         item.last  = (k == cut) && shape != SH_ABANDON &&
                      (shape != SH_NOISE || $urandom_range(0, 1) == 1);
         item.mode  = CHK_MODEL;
         item.word  = NO_WORD;
         stim_q.push_back(item);
      end
      file_count++;
   endtask

   // ------------------------------------------------------------------------
   // byte source
   // ------------------------------------------------------------------------
   initial begin : drive_bytes
      int i;
      int gap_pct;
      int calm_from;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.byte_value <= 8'h00;
      req_bus.first_byte <= 1'b0;
      req_bus.final_byte <= 1'b0;
      cur_item <= '0;
      rx_idle_pct <= 0;
      gap_pct = 0;
      fail_count = 0;
      file_count = 0;
      clear_parser();

      foreach (directed_rows[r])
         stim_q.push_back(directed_rows[r]);
      for (i = 0; i <= SH_NOISE; i++)
         add_file(file_shape_type'(i));
      while (stim_q.size() < 550)
         case ($urandom_range(0, 19))
            8:       add_file(SH_BAD_MAGIC);
            9, 10:   add_file(SH_BAD_FMT);
            11, 12:  add_file(SH_DETOUR);
            13:      add_file(SH_EMPTY);
            14:      add_file(SH_LONG);
            15, 16:  add_file(SH_TRUNC);
            17:      add_file(SH_ABANDON);
            18:      add_file(SH_OPEN);
            19:      add_file(SH_NOISE);
            default: add_file(SH_GOOD);
         endcase
      calm_from = stim_q.size() - CALM_BYTES;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < stim_q.size(); i++) begin
         if (i >= calm_from) begin
            gap_pct = 0;
         end else if (stim_q[i].first) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 15;
               default: gap_pct = 45;
            endcase
         end
         rx_idle_pct <= gap_pct;
         if ($urandom_range(0, 99) < gap_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.byte_value <= stim_q[i].b;
         req_bus.first_byte <= stim_q[i].first;
         req_bus.final_byte <= stim_q[i].last;
         cur_item <= stim_q[i];
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
      end
      req_bus.valid <= 1'b0;

      while (owed_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d files; checked %0d result words, %0d of them data.",
               bytes_taken, file_count, words_seen, data_seen);
      $display("Files closed: ok %0d, bad magic %0d, no fmt %0d, bad format %0d, no data %0d.",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result sink: random stalls, plus one long hold-off while data flows
   // ------------------------------------------------------------------------
   initial begin : take_words
      int  n;
      bit  held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && rsp_bus.valid && rsp_bus.has_byte && !rsp_bus.done_res) begin
            // hold off so the output word backs up into the byte input
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            n = 60;
            while (n > 0) begin
               @(posedge clock);
               n--;
            end
         end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // predict on each accepted byte, compare each accepted word
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic                    produced;
      wavhp_pkg::rsp_word_type w;
      wavhp_pkg::rsp_word_type e;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            bytes_taken++;
            parse_byte(cur_item.b, cur_item.first, cur_item.last, produced, w);
            if (cur_item.mode == CHK_MODEL && produced)
               owed_words.push_back(w);
            else if (cur_item.mode == CHK_TYPED)
               owed_words.push_back(cur_item.word);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_seen++;
            if (rsp_bus.has_byte === 1'b1)
               data_seen++;
            if (rsp_bus.done_res === 1'b1 && rsp_bus.status <= wavhp_pkg::ST_NO_DATA)
               status_tally[rsp_bus.status]++;
            if (owed_words.size() == 0) begin
               $error("result word with none expected: has_byte %b done_res %b status %0d",
                      rsp_bus.has_byte, rsp_bus.done_res, rsp_bus.status);
               fail_count++;
            end else begin
               e = owed_words.pop_front();
               if (rsp_bus.has_byte !== e.has_byte) begin
                  $error("has_byte: expected %b, got %b", e.has_byte, rsp_bus.has_byte);
                  fail_count++;
               end
               if (rsp_bus.data_byte !== e.data_byte) begin
                  $error("data_byte: expected %h, got %h", e.data_byte, rsp_bus.data_byte);
                  fail_count++;
               end
               if (rsp_bus.done_res !== e.done_res) begin
                  $error("done_res: expected %b, got %b", e.done_res, rsp_bus.done_res);
                  fail_count++;
               end
               if (rsp_bus.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_bus.status);
                  fail_count++;
               end
               if (rsp_bus.sample_rate !== e.sample_rate) begin
                  $error("sample_rate: expected %h, got %h", e.sample_rate,
                         rsp_bus.sample_rate);
                  fail_count++;
               end
               if (rsp_bus.channel_count !== e.channel_count) begin
                  $error("channel_count: expected %h, got %h", e.channel_count,
                         rsp_bus.channel_count);
                  fail_count++;
               end
               if (rsp_bus.data_length !== e.data_length) begin
                  $error("data_length: expected %h, got %h", e.data_length,
                         rsp_bus.data_length);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* wav_header_parser_core.f */
hdl/wavhp_pkg.sv
hdl/wavhp_if.sv
hdl/wavhp_parse.sv
hdl/wav_header_parser_core.sv
tb/tb_wav_header_parser_core.sv
